>>> rtl/core/cdq_pkg.sv
// cdq_pkg: shared types and codes for the circular deque.
// Used by cdq_ctrl, cdq_dp, circular_deque, deque_checker and tb_top; depends on nothing.
`default_nettype none

package cdq_pkg;

	localparam int unsigned DATA_W = 32;

	typedef enum logic [1:0] {
		MODE_PUSH_BACK  = 2'd0,
		MODE_PUSH_FRONT = 2'd1,
		MODE_POP_FRONT  = 2'd2,
		MODE_POP_BACK   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		STAT_DONE  = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_READ = 1'b1
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic exec;    // input beat taken this cycle
		logic finish;  // pop read data valid, load it into the result
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic pop_req; // current input beat asks for a pop
	} dp_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/cdq_ram.sv
// cdq_ram: generic single-write, single-read RAM with registered read.
// No dependencies.
`default_nettype none

module cdq_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> rtl/core/cdq_ctrl.sv
// cdq_ctrl: handshake controller for the circular deque.
// Depends on cdq_pkg.
`default_nettype none

module cdq_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	input  wire cdq_pkg::dp_stat_t stat,
	output cdq_pkg::cmd_t          cmd
);

	cdq_pkg::state_t state_q, state_d;
	logic            out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cdq_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		cmd.exec   = 1'b0;
		cmd.finish = 1'b0;
		case (state_q)
			cdq_pkg::S_IDLE: begin
				// result register is free or drains this cycle
				in_ready = !out_valid_q || out_ready;
				cmd.exec = in_valid && in_ready;
				if (cmd.exec && stat.pop_req) begin
					state_d = cdq_pkg::S_READ;
				end
			end
			cdq_pkg::S_READ: begin
				cmd.finish = 1'b1;
				state_d    = cdq_pkg::S_IDLE;
			end
			default: begin
				state_d = cdq_pkg::S_IDLE;
			end
		endcase

		out_valid_d = out_valid_q;
		if (out_valid_q && out_ready) begin
			out_valid_d = 1'b0;
		end
		if ((cmd.exec && !stat.pop_req) || cmd.finish) begin
			out_valid_d = 1'b1;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

>>> rtl/core/cdq_dp.sv
// cdq_dp: pointers, count, entry RAM and result register of the deque.
// Depends on cdq_pkg and cdq_ram.
`default_nettype none

module cdq_dp #(
	parameter int unsigned CAPACITY = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire cdq_pkg::cmd_t                 cmd,
	output cdq_pkg::dp_stat_t                  stat,
	input  wire logic [1:0]                    mode,
	input  wire logic signed [cdq_pkg::DATA_W-1:0] push_value,
	output logic signed [cdq_pkg::DATA_W-1:0]  pop_value,
	output logic [1:0]                         status,
	output logic                               now_empty
);

	localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

	logic [IDX_W-1:0] head_q, tail_q, head_d, tail_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [cdq_pkg::DATA_W-1:0] pop_value_q;
	cdq_pkg::status_t status_q, status_d;
	logic             now_empty_q;

	logic             is_pop, is_empty, is_full;
	logic             we;
	logic [IDX_W-1:0] waddr, raddr;
	logic [cdq_pkg::DATA_W-1:0] rdata;

	function automatic logic [IDX_W-1:0] slot_next(input logic [IDX_W-1:0] s);
		return (s == LAST_IDX) ? '0 : s + 1'b1;
	endfunction

	function automatic logic [IDX_W-1:0] slot_prev(input logic [IDX_W-1:0] s);
		return (s == '0) ? LAST_IDX : s - 1'b1;
	endfunction

	assign is_pop       = mode[1];
	assign stat.pop_req = is_pop;
	assign is_empty     = (count_q == '0);
	assign is_full      = (count_q == FULL_CNT);

	always_comb begin
		head_d   = head_q;
		tail_d   = tail_q;
		count_d  = count_q;
		status_d = cdq_pkg::STAT_DONE;
		we       = 1'b0;
		waddr    = '0;
		raddr    = tail_q;
		case (cdq_pkg::mode_t'(mode))
			cdq_pkg::MODE_PUSH_BACK, cdq_pkg::MODE_PUSH_FRONT: begin
				if (is_full) begin
					status_d = cdq_pkg::STAT_FULL;
				end else begin
					we      = 1'b1;
					count_d = count_q + 1'b1;
					if (is_empty) begin
						head_d = '0;
						tail_d = '0;
						waddr  = '0;
					end else if (mode == cdq_pkg::MODE_PUSH_BACK) begin
						tail_d = slot_next(tail_q);
						waddr  = tail_d;
					end else begin
						head_d = slot_prev(head_q);
						waddr  = head_d;
					end
				end
			end
			cdq_pkg::MODE_POP_FRONT, cdq_pkg::MODE_POP_BACK: begin
				raddr = (mode == cdq_pkg::MODE_POP_FRONT) ? head_q : tail_q;
				if (is_empty) begin
					status_d = cdq_pkg::STAT_EMPTY;
				end else begin
					count_d = count_q - 1'b1;
					if (count_d == '0) begin
						head_d = '0;
						tail_d = '0;
					end else if (mode == cdq_pkg::MODE_POP_FRONT) begin
						head_d = slot_next(head_q);
					end else begin
						tail_d = slot_prev(tail_q);
					end
				end
			end
			default: begin
				status_d = cdq_pkg::STAT_DONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else if (cmd.exec) begin
			head_q  <= head_d;
			tail_q  <= tail_d;
			count_q <= count_d;
		end
	end

	// result register: status/empty at the input beat, pop data in the following cycle
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_q    <= status_d;
			now_empty_q <= (count_d == '0);
			pop_value_q <= '0;
		end else if (cmd.finish && status_q == cdq_pkg::STAT_DONE) begin
			pop_value_q <= rdata;
		end
	end

	cdq_ram #(
		.WIDTH(cdq_pkg::DATA_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (cmd.exec && we),
		.waddr(waddr),
		.wdata(push_value),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign pop_value = pop_value_q;
	assign status    = status_q;
	assign now_empty = now_empty_q;

endmodule

`default_nettype wire

>>> rtl/core/circular_deque.sv
// circular_deque: top level of a double-ended queue in a ring RAM.
// Depends on cdq_pkg, cdq_ctrl, cdq_dp (and through it cdq_ram).
//
//   channel  handshake            payload
//   -------  -------------------  -----------------------------
//   input    in_valid / in_ready  mode, push_value
//   output   out_valid/out_ready  pop_value, status, now_empty
//
// A push completes at its input beat; a pop goes on through the read state for the registered RAM read.
// The result sits in an output register; the next beat is taken while it
// waits, provided it is drained in the same cycle as a new beat enters.
// Reset clears the pointers and count; the RAM needs no clearing pass.
// A stalled output holds the input off; nothing is lost or repeated.
`default_nettype none

module circular_deque #(
	parameter int unsigned CAPACITY = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [1:0]                        mode,
	input  wire logic signed [cdq_pkg::DATA_W-1:0] push_value,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic signed [cdq_pkg::DATA_W-1:0]      pop_value,
	output logic [1:0]                             status,
	output logic                                   now_empty
);

	cdq_pkg::cmd_t     cmd;
	cdq_pkg::dp_stat_t stat;

	cdq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	cdq_dp #(
		.CAPACITY(CAPACITY)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.mode      (mode),
		.push_value(push_value),
		.pop_value (pop_value),
		.status    (status),
		.now_empty (now_empty)
	);

endmodule

`default_nettype wire

>>> tb/deque_checker.sv
`timescale 1ns / 1ps
// deque_checker: watches both channels of circular_deque, predicts every result
// from its own copy of the deque and compares beat by beat.
// Depends on cdq_pkg for the operation and status codes.

module deque_checker
	import cdq_pkg::*;
#(
	parameter int unsigned DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [1:0]         mode,
	input  logic signed [31:0] push_value,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [31:0] pop_value,
	input  logic [1:0]         status,
	input  logic               now_empty,
	output int unsigned        err_count,
	output int unsigned        backlog
);

	typedef struct {
		logic signed [31:0] value;
		status_t            stat;
		logic               empty;
	} deque_result_t;

	// shadow deque
	logic signed [31:0] ring [DEPTH];
	int unsigned front_slot = 0;
	int unsigned back_slot = 0;
	int unsigned held = 0;

	deque_result_t owed_results[$];
	deque_result_t want;
	int unsigned n_errors = 0;
	int unsigned n_owed = 0;

	assign err_count = n_errors;
	assign backlog = n_owed;

	task automatic flag_error(input string what);
		$display("%0t ns ERROR %s", $time, what);
		n_errors++;
	endtask

	task automatic apply_op(input mode_t op, input logic signed [31:0] v);
		deque_result_t r;
		r.value = '0;
		r.stat = STAT_DONE;
		case (op)
			MODE_PUSH_BACK, MODE_PUSH_FRONT: begin
				if (held >= DEPTH) begin
					r.stat = STAT_FULL;
				end else begin
					// first entry always lands in slot 0, whichever end
					if (held == 0) begin
						front_slot = 0;
						back_slot = 0;
					end else if (op == MODE_PUSH_BACK) begin
						back_slot = (back_slot + 1) % DEPTH;
					end else begin
						front_slot = (front_slot + DEPTH - 1) % DEPTH;
					end
					ring[(op == MODE_PUSH_BACK) ? back_slot : front_slot] = v;
					held++;
				end
			end
			default: begin
				if (held == 0) begin
					r.stat = STAT_EMPTY;
				end else begin
					r.value = ring[(op == MODE_POP_FRONT) ? front_slot : back_slot];
					held--;
					if (held == 0) begin
						front_slot = 0;
						back_slot = 0;
					end else if (op == MODE_POP_FRONT) begin
						front_slot = (front_slot + 1) % DEPTH;
					end else begin
						back_slot = (back_slot + DEPTH - 1) % DEPTH;
					end
				end
			end
		endcase
		r.empty = (held == 0);
		owed_results.insert(owed_results.size(), r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_slot = 0;
			back_slot = 0;
			held = 0;
			owed_results.delete();
			n_owed = 0;
		end else begin
			// result first: a beat taken now cannot be the result leaving now
			if (out_valid && out_ready) begin
				if (owed_results.size() == 0) begin
					flag_error("result beat with nothing expected");
				end else begin
					want = owed_results[0];
					owed_results.delete(0);
					if (pop_value !== want.value)
						flag_error($sformatf("pop_value %0d, expected %0d",
							pop_value, want.value));
					if (status !== want.stat)
						flag_error($sformatf("status %0d, expected %0d",
							status, want.stat));
					if (now_empty !== want.empty)
						flag_error($sformatf("now_empty %0b, expected %0b",
							now_empty, want.empty));
				end
			end
			if (in_valid && in_ready)
				apply_op(mode_t'(mode), push_value);
			n_owed = owed_results.size();
		end
	end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// tb_top: clock, reset and stimulus for circular_deque, plus the final verdict.
// Depends on cdq_pkg, the circular_deque RTL and deque_checker.

module tb_top;
	import cdq_pkg::*;

	localparam int unsigned DEPTH = 16;
	localparam int unsigned RANDOM_OPS = 1300;
	localparam int unsigned LONG_HOLD = 200;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [1:0]         mode;
	logic signed [31:0] push_value;
	logic               out_valid;
	logic               out_ready;
	logic signed [31:0] pop_value;
	logic [1:0]         status;
	logic               now_empty;

	int unsigned err_count;
	int unsigned backlog;
	int unsigned burst_left = 0;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;

	always #1 clk = ~clk;

	circular_deque #(.CAPACITY(DEPTH)) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.mode       (mode),
		.push_value (push_value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.pop_value  (pop_value),
		.status     (status),
		.now_empty  (now_empty)
	);

	deque_checker #(.DEPTH(DEPTH)) chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.mode       (mode),
		.push_value (push_value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.pop_value  (pop_value),
		.status     (status),
		.now_empty  (now_empty),
		.err_count  (err_count),
		.backlog    (backlog)
	);

	// one input beat; a new burst may open with an idle gap
	task automatic issue(input mode_t op, input logic signed [31:0] v);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 32);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		mode <= op;
		push_value <= v;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// receiver: own stall pattern, plus one long hold-off to back the block up
	initial begin
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				case ($urandom_range(0, 3))
					0: begin
						out_ready <= 1'b1;
						repeat ($urandom_range(5, 40)) @(posedge clk);
					end
					1: begin
						repeat ($urandom_range(5, 30)) begin
							out_ready <= 1'($urandom_range(0, 1));
							@(posedge clk);
						end
					end
					2: begin
						out_ready <= 1'b0;
						repeat ($urandom_range(1, 6)) @(posedge clk);
					end
					default: begin
						repeat ($urandom_range(5, 30)) begin
							out_ready <= ($urandom_range(0, 3) != 0);
							@(posedge clk);
						end
					end
				endcase
			end
		end
	end

	initial begin
		int unsigned push_pct;
		int unsigned phase_left;
		int unsigned pick;
		logic signed [31:0] v;
		mode_t op;

		arst_n <= 1'b0;
		in_valid <= 1'b0;
		mode <= MODE_PUSH_BACK;
		push_value <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty deque, both pop ends, push at either end of an empty deque
		issue(MODE_POP_FRONT, 32'sd0);
		issue(MODE_POP_BACK, 32'sh7fffffff);
		issue(MODE_PUSH_FRONT, 32'sh7fffffff);
		issue(MODE_POP_BACK, 32'sd0);
		issue(MODE_PUSH_BACK, 32'sh80000000);
		issue(MODE_PUSH_FRONT, -32'sd1);
		issue(MODE_POP_FRONT, 32'sd0);
		issue(MODE_POP_FRONT, 32'sd0);
		// fill from both ends, wrapping round slot 0, then push while full
		for (int i = 0; i < DEPTH; i++)
			issue((i % 2) ? MODE_PUSH_FRONT : MODE_PUSH_BACK,
				(i == 0) ? 32'sh80000000 : 32'(i) * 32'sh11111111);
		issue(MODE_PUSH_BACK, 32'sh7fffffff);
		issue(MODE_PUSH_FRONT, -32'sd1);

		hold_req = 1'b1;
		push_pct = 50;
		phase_left = 0;
		for (int n = 0; n < RANDOM_OPS; n++) begin
			// phases lean to push or pop so both full and empty are hit often
			if (phase_left == 0) begin
				phase_left = $urandom_range(20, 80);
				case ($urandom_range(0, 4))
					0: push_pct = 85;
					1: push_pct = 15;
					2: push_pct = 70;
					3: push_pct = 30;
					default: push_pct = 50;
				endcase
			end
			phase_left--;
			pick = $urandom_range(0, 99);
			if (pick < push_pct)
				op = $urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
			else
				op = $urandom_range(0, 1) ? MODE_POP_FRONT : MODE_POP_BACK;
			case ($urandom_range(0, 11))
				0: v = 32'sh80000000;
				1: v = 32'sh7fffffff;
				2: v = 32'sd0;
				3: v = -32'sd1;
				default: v = $urandom;
			endcase
			issue(op, v);
		end

		in_valid <= 1'b0;
		// let the checker take the last beat before watching its backlog
		@(posedge clk);
		while (backlog != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (err_count == 0 && backlog == 0) begin
			$display("PASS circular_deque");
		end else begin
			$display("FAIL circular_deque");
		end
		$finish;
	end

	initial begin
		#1000000;
		$display("FAIL circular_deque");
		$finish;
	end

endmodule

>>> sim.f
rtl/core/cdq_pkg.sv
rtl/core/cdq_ram.sv
rtl/core/cdq_ctrl.sv
rtl/core/cdq_dp.sv
rtl/core/circular_deque.sv
tb/deque_checker.sv
tb/tb_top.sv
